FILE: rtl/core/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants of the adaptive replacement cache policy block:
// list codes, result location codes, controller commands and status.
// ----------------------------------------------------------------------------
package arc_pkg;

    // Width of capacity and adaptive target
    localparam int PW = 5;
    localparam logic [PW-1:0] CAP_RESET = 5'd16;

    // Register index of cache_capacity
    localparam logic REG_CAP = 1'b0;

    typedef enum logic [1:0] {
        LIST_T1 = 2'd0,
        LIST_T2 = 2'd1,
        LIST_B1 = 2'd2,
        LIST_B2 = 2'd3
    } t_list;

    localparam logic [2:0] FOUND_NONE = 3'd0;
    localparam logic [2:0] FOUND_T1   = 3'd1;
    localparam logic [2:0] FOUND_T2   = 3'd2;
    localparam logic [2:0] FOUND_B1   = 3'd3;
    localparam logic [2:0] FOUND_B2   = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LATCH  = 4'd1,
        OP_SCAN   = 4'd2,
        OP_DIV    = 4'd3,
        OP_ADJ    = 4'd4,
        OP_FIND   = 4'd5,
        OP_UNLINK = 4'd6,
        OP_NOTE   = 4'd7,
        OP_PUSH   = 4'd8,
        OP_INSERT = 4'd9,
        OP_OUT    = 4'd10
    } t_op;

    typedef enum logic {
        SRC_HIT = 1'b0,
        SRC_SEL = 1'b1
    } t_src;

    typedef struct packed {
        t_op   op;
        t_src  src;
        t_list list;
    } t_cmd;

    typedef struct packed {
        logic  scan_done;
        logic  found;
        t_list where;
        logic  div_done;
        logic  out_busy;
        logic  l1_ge_c;
        logic  t1_lt_c;
        logic  total_ge_c;
        logic  total_ge_2c;
        logic  repl_t1;
    } t_stat;

endpackage

FILE: rtl/core/arc_div.sv
// ----------------------------------------------------------------------------
// arc_div
// Restoring divider for list counts, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arc_div #(
    parameter int W = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    localparam int NW = $clog2(W + 1);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    rem_sh;
    logic          take;

    assign rem_sh = {r_rem[W-1:0], r_quo[W-1]};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= NW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/core/arc_dpath.sv
// ----------------------------------------------------------------------------
// arc_dpath
// Entry table, tag memory, list counts, adaptive target and result register.
// Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module arc_dpath #(
    parameter int MAX_CAPACITY = 16,
    parameter int KEY_WIDTH    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  arc_pkg::t_cmd            i_cmd,
    output arc_pkg::t_stat           o_stat,
    input  logic                     i_cfg_we,
    input  logic [arc_pkg::PW-1:0]   i_cfg_wdata,
    output logic [arc_pkg::PW-1:0]   o_cap,
    input  logic [KEY_WIDTH-1:0]     i_access_key,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic [2:0]               o_found_in,
    output logic                     o_released_valid,
    output logic [KEY_WIDTH-1:0]     o_released_key,
    output logic [arc_pkg::PW-1:0]   o_target_size
);

    localparam int SLOTS = 2 * MAX_CAPACITY;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int EW    = (CW > arc_pkg::PW ? CW : arc_pkg::PW) + 2;
    localparam int PW    = arc_pkg::PW;

    // Entry table
    logic [SLOTS-1:0]    r_vld;
    arc_pkg::t_list      r_lst [SLOTS];
    logic [SW-1:0]       r_rec [SLOTS];
    logic [CW-1:0]       r_cnt [4];
    logic [KEY_WIDTH-1:0] mem [SLOTS];
    logic [KEY_WIDTH-1:0] r_rdata;

    logic [PW-1:0]       r_p;
    logic [PW-1:0]       r_cap;

    // Per-access state
    logic [KEY_WIDTH-1:0] r_key;
    logic [CW-1:0]       r_scan;
    logic                r_pend;
    logic [SW-1:0]       r_pidx;
    logic                r_found;
    arc_pkg::t_list      r_where;
    logic [SW-1:0]       r_hit_idx;
    logic [SW-1:0]       r_sel;
    logic                r_sel_ok;
    logic                r_rel_v;
    logic [KEY_WIDTH-1:0] r_rel_key;
    logic                r_den_zero;

    // Result register
    logic                r_ov;
    logic                r_o_hit;
    logic [2:0]          r_o_found;
    logic                r_o_relv;
    logic [KEY_WIDTH-1:0] r_o_relk;
    logic [PW-1:0]       r_o_p;

    logic [PW-1:0]       c_eff;
    logic [EW-1:0]       t1e, t2e, b1e, b2e, ce, pe, l1, tot;
    logic                in_b2;
    logic                scan_live;
    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       op_idx;
    logic                op_ok;
    arc_pkg::t_list      ul_list;
    logic                push_en;
    logic [SW-1:0]       push_idx;
    arc_pkg::t_list      push_list;
    logic [CW-1:0]       lru_rec;
    logic [SLOTS-1:0]    match;
    logic [SW-1:0]       find_idx;
    logic [SW-1:0]       free_idx;
    logic [CW-1:0]       div_num, div_den;
    logic                div_done;
    logic [CW-1:0]       div_quo;
    logic [EW-1:0]       d_step, p_up, p_dn;
    logic [2:0]          found_code;

    always_comb begin
        if (r_cap == '0) begin
            c_eff = PW'(1);
        end else if (int'(r_cap) > MAX_CAPACITY) begin
            c_eff = PW'(MAX_CAPACITY);
        end else begin
            c_eff = r_cap;
        end
    end

    assign t1e   = EW'(r_cnt[arc_pkg::LIST_T1]);
    assign t2e   = EW'(r_cnt[arc_pkg::LIST_T2]);
    assign b1e   = EW'(r_cnt[arc_pkg::LIST_B1]);
    assign b2e   = EW'(r_cnt[arc_pkg::LIST_B2]);
    assign ce    = EW'(c_eff);
    assign pe    = EW'(r_p);
    assign l1    = t1e + b1e;
    assign tot   = l1 + t2e + b2e;
    assign in_b2 = r_found && (r_where == arc_pkg::LIST_B2);

    assign scan_live = (i_cmd.op == arc_pkg::OP_SCAN) && (r_scan < CW'(SLOTS));
    assign rd_addr   = scan_live ? r_scan[SW-1:0] : r_sel;

    // Free slot for an insert, taken after the evictions of this access
    always_comb begin
        free_idx = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (!r_vld[j]) begin
                free_idx = SW'(j);
            end
        end
    end

    // Tag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == arc_pkg::OP_INSERT) begin
            mem[free_idx] <= r_key;
        end
        r_rdata <= mem[rd_addr];
    end

    assign op_idx  = (i_cmd.src == arc_pkg::SRC_HIT) ? r_hit_idx : r_sel;
    assign op_ok   = (i_cmd.src == arc_pkg::SRC_HIT) || r_sel_ok;
    assign ul_list = r_lst[op_idx];

    always_comb begin
        push_en   = 1'b0;
        push_idx  = op_idx;
        push_list = i_cmd.list;
        case (i_cmd.op)
            arc_pkg::OP_PUSH: begin
                push_en = op_ok;
            end
            arc_pkg::OP_INSERT: begin
                push_en   = 1'b1;
                push_idx  = free_idx;
                push_list = arc_pkg::LIST_T1;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    // LRU of a list: the valid entry whose recency is count - 1
    assign lru_rec = r_cnt[i_cmd.list] - 1'b1;
    always_comb begin
        find_idx = '0;
        for (int j = 0; j < SLOTS; j++) begin
            match[j] = r_vld[j] && (r_lst[j] == i_cmd.list) && (CW'(r_rec[j]) == lru_rec);
            find_idx = find_idx | (match[j] ? SW'(j) : '0);
        end
    end

    // Entry table and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int l = 0; l < 4; l++) begin
                r_cnt[l] <= '0;
            end
        end else if (i_cfg_we) begin
            r_vld <= '0;
            for (int l = 0; l < 4; l++) begin
                r_cnt[l] <= '0;
            end
        end else if (i_cmd.op == arc_pkg::OP_UNLINK && op_ok) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (r_vld[j] && (r_lst[j] == ul_list) && (r_rec[j] > r_rec[op_idx])) begin
                    r_rec[j] <= r_rec[j] - 1'b1;
                end
            end
            r_vld[op_idx] <= 1'b0;
            if (r_cnt[ul_list] != '0) begin
                r_cnt[ul_list] <= r_cnt[ul_list] - 1'b1;
            end
        end else if (push_en) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (r_vld[j] && (r_lst[j] == push_list)) begin
                    r_rec[j] <= r_rec[j] + 1'b1;
                end
            end
            r_lst[push_idx] <= push_list;
            r_rec[push_idx] <= '0;
            r_vld[push_idx] <= 1'b1;
            r_cnt[push_list] <= r_cnt[push_list] + 1'b1;
        end
    end

    // Key scan, victim selection and release note
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_sel_ok <= 1'b0;
            r_rel_v  <= 1'b0;
        end else begin
            case (i_cmd.op)
                arc_pkg::OP_LATCH: begin
                    r_key     <= i_access_key;
                    r_scan    <= '0;
                    r_pend    <= 1'b0;
                    r_found   <= 1'b0;
                    r_rel_v   <= 1'b0;
                    r_rel_key <= '0;
                end
                arc_pkg::OP_SCAN: begin
                    r_pend <= scan_live;
                    if (scan_live) begin
                        r_scan <= r_scan + 1'b1;
                        r_pidx <= r_scan[SW-1:0];
                    end
                    if (r_pend) begin
                        if (r_vld[r_pidx] && (r_rdata == r_key) && !r_found) begin
                            r_found   <= 1'b1;
                            r_hit_idx <= r_pidx;
                            r_where   <= r_lst[r_pidx];
                        end
                    end
                end
                arc_pkg::OP_FIND: begin
                    r_sel    <= find_idx;
                    r_sel_ok <= (r_cnt[i_cmd.list] != '0) && (|match);
                end
                arc_pkg::OP_NOTE: begin
                    // keep only the first key that leaves the data lists
                    if (r_sel_ok && !r_rel_v && (i_cmd.list == arc_pkg::LIST_T1 ||
                                                 i_cmd.list == arc_pkg::LIST_T2)) begin
                        r_rel_v   <= 1'b1;
                        r_rel_key <= r_rdata;
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // Adaptive target
    always_comb begin
        if (r_where == arc_pkg::LIST_B1) begin
            div_num = r_cnt[arc_pkg::LIST_B2];
            div_den = r_cnt[arc_pkg::LIST_B1];
        end else begin
            div_num = r_cnt[arc_pkg::LIST_B1];
            div_den = r_cnt[arc_pkg::LIST_B2];
        end
    end

    arc_div #(
        .W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == arc_pkg::OP_DIV),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign d_step = (r_den_zero || div_quo == '0) ? EW'(1) : EW'(div_quo);
    assign p_up   = pe + d_step;
    assign p_dn   = pe - d_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p   <= '0;
            r_cap <= arc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_p   <= '0;
            r_cap <= i_cfg_wdata;
        end else if (i_cmd.op == arc_pkg::OP_ADJ) begin
            if (r_where == arc_pkg::LIST_B1) begin
                r_p <= (p_up > ce) ? c_eff : p_up[PW-1:0];
            end else begin
                r_p <= (pe > d_step) ? p_dn[PW-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == arc_pkg::OP_DIV) begin
            r_den_zero <= (div_den == '0);
        end
    end

    // Result register
    always_comb begin
        found_code = arc_pkg::FOUND_NONE;
        if (r_found) begin
            case (r_where)
                arc_pkg::LIST_T1: found_code = arc_pkg::FOUND_T1;
                arc_pkg::LIST_T2: found_code = arc_pkg::FOUND_T2;
                arc_pkg::LIST_B1: found_code = arc_pkg::FOUND_B1;
                arc_pkg::LIST_B2: found_code = arc_pkg::FOUND_B2;
                default:          found_code = arc_pkg::FOUND_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == arc_pkg::OP_OUT) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == arc_pkg::OP_OUT) begin
            r_o_hit   <= r_found && (r_where == arc_pkg::LIST_T1 ||
                                     r_where == arc_pkg::LIST_T2);
            r_o_found <= found_code;
            r_o_relv  <= r_rel_v;
            r_o_relk  <= r_rel_key;
            r_o_p     <= r_p;
        end
    end

    assign o_stat.scan_done   = (r_scan == CW'(SLOTS)) && !r_pend;
    assign o_stat.found       = r_found;
    assign o_stat.where       = r_where;
    assign o_stat.div_done    = div_done;
    assign o_stat.out_busy    = r_ov && i_stall;
    assign o_stat.l1_ge_c     = (l1 >= ce);
    assign o_stat.t1_lt_c     = (t1e < ce);
    assign o_stat.total_ge_c  = (tot >= ce);
    assign o_stat.total_ge_2c = (tot >= (ce << 1));
    assign o_stat.repl_t1     = (t1e != '0) && ((t1e > pe) || (in_b2 && t1e == pe));

    assign o_cap            = r_cap;
    assign o_valid          = r_ov;
    assign o_hit            = r_o_hit;
    assign o_found_in       = r_o_found;
    assign o_released_valid = r_o_relv;
    assign o_released_key   = r_o_relk;
    assign o_target_size    = r_o_p;

endmodule

FILE: rtl/core/arc_ctrl.sv
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer of one access: key scan, ARC case selection, evictions,
// target update and insertion, issued as commands to the datapath.
// ----------------------------------------------------------------------------
module arc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  arc_pkg::t_stat i_stat,
    output arc_pkg::t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_SCAN   = 15'b000000000000010,
        ST_DECIDE = 15'b000000000000100,
        ST_DIVS   = 15'b000000000001000,
        ST_DIVW   = 15'b000000000010000,
        ST_ADJ    = 15'b000000000100000,
        ST_UNHIT  = 15'b000000001000000,
        ST_REPL   = 15'b000000010000000,
        ST_FIND   = 15'b000000100000000,
        ST_UNL    = 15'b000001000000000,
        ST_NOTE   = 15'b000010000000000,
        ST_MOVE   = 15'b000100000000000,
        ST_INS    = 15'b001000000000000,
        ST_PUSHH  = 15'b010000000000000,
        ST_OUTW   = 15'b100000000000000
    } t_state;

    t_state         r_state, n_state;
    arc_pkg::t_list r_evl, n_evl;
    arc_pkg::t_list r_evdst, n_evdst;
    logic           r_evmove, n_evmove;
    logic           r_need_repl, n_need_repl;
    t_state         after_evict;

    assign after_evict = r_need_repl ? ST_REPL : (i_stat.found ? ST_PUSHH : ST_INS);

    always_comb begin
        n_state     = r_state;
        n_evl       = r_evl;
        n_evdst     = r_evdst;
        n_evmove    = r_evmove;
        n_need_repl = r_need_repl;
        o_cmd.op    = arc_pkg::OP_NONE;
        o_cmd.src   = arc_pkg::SRC_SEL;
        o_cmd.list  = r_evl;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = arc_pkg::OP_LATCH;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.op = arc_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_evmove    = 1'b0;
                n_need_repl = 1'b0;
                if (i_stat.found) begin
                    if (i_stat.where == arc_pkg::LIST_T1 || i_stat.where == arc_pkg::LIST_T2) begin
                        n_state = ST_UNHIT;
                    end else begin
                        n_state = ST_DIVS;
                    end
                end else if (i_stat.l1_ge_c) begin
                    n_state = ST_FIND;
                    if (i_stat.t1_lt_c) begin
                        n_evl       = arc_pkg::LIST_B1;
                        n_need_repl = 1'b1;
                    end else begin
                        n_evl = arc_pkg::LIST_T1;
                    end
                end else if (i_stat.total_ge_c) begin
                    if (i_stat.total_ge_2c) begin
                        n_evl       = arc_pkg::LIST_B2;
                        n_need_repl = 1'b1;
                        n_state     = ST_FIND;
                    end else begin
                        n_state = ST_REPL;
                    end
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_DIVS: begin
                o_cmd.op = arc_pkg::OP_DIV;
                n_state  = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                o_cmd.op = arc_pkg::OP_ADJ;
                n_state  = ST_UNHIT;
            end
            ST_UNHIT: begin
                o_cmd.op  = arc_pkg::OP_UNLINK;
                o_cmd.src = arc_pkg::SRC_HIT;
                if (i_stat.where == arc_pkg::LIST_T1 || i_stat.where == arc_pkg::LIST_T2) begin
                    n_state = ST_PUSHH;
                end else begin
                    n_state = ST_REPL;
                end
            end
            ST_REPL: begin
                n_evmove    = 1'b1;
                n_need_repl = 1'b0;
                n_state     = ST_FIND;
                if (i_stat.repl_t1) begin
                    n_evl   = arc_pkg::LIST_T1;
                    n_evdst = arc_pkg::LIST_B1;
                end else begin
                    n_evl   = arc_pkg::LIST_T2;
                    n_evdst = arc_pkg::LIST_B2;
                end
            end
            ST_FIND: begin
                o_cmd.op = arc_pkg::OP_FIND;
                n_state  = ST_UNL;
            end
            ST_UNL: begin
                o_cmd.op = arc_pkg::OP_UNLINK;
                n_state  = ST_NOTE;
            end
            ST_NOTE: begin
                o_cmd.op = arc_pkg::OP_NOTE;
                n_state  = r_evmove ? ST_MOVE : after_evict;
            end
            ST_MOVE: begin
                o_cmd.op   = arc_pkg::OP_PUSH;
                o_cmd.list = r_evdst;
                n_state    = after_evict;
            end
            ST_INS: begin
                o_cmd.op = arc_pkg::OP_INSERT;
                n_state  = ST_OUTW;
            end
            ST_PUSHH: begin
                o_cmd.op   = arc_pkg::OP_PUSH;
                o_cmd.src  = arc_pkg::SRC_HIT;
                o_cmd.list = arc_pkg::LIST_T2;
                n_state    = ST_OUTW;
            end
            ST_OUTW: begin
                // hold until the result register can take the transaction
                if (!i_stat.out_busy) begin
                    o_cmd.op = arc_pkg::OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_evl       <= arc_pkg::LIST_T1;
            r_evdst     <= arc_pkg::LIST_B1;
            r_evmove    <= 1'b0;
            r_need_repl <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_evl       <= n_evl;
            r_evdst     <= n_evdst;
            r_evmove    <= n_evmove;
            r_need_repl <= n_need_repl;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/core/arc_replacement_policy.sv
// Accesses: one at a time; a new access is taken only while the block is idle.
//   Each access scans every tag memory slot through the single read port, and a ghost
//   hit also runs the serial divider.
// Reset: all lists empty, target 0, capacity 16; a capacity write empties the
//   lists and clears the target.
// ----------------------------------------------------------------------------
// arc_replacement_policy
// Adaptive replacement cache policy over fixed-width keys with an APB
// capacity register.
// ----------------------------------------------------------------------------
module arc_replacement_policy #(
    parameter int MAX_CAPACITY = 16,
    parameter int KEY_WIDTH    = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [KEY_WIDTH-1:0]   i_access_key,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_hit,
    output logic [2:0]             o_found_in,
    output logic                   o_released_valid,
    output logic [KEY_WIDTH-1:0]   o_released_key,
    output logic [arc_pkg::PW-1:0] o_target_size,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    arc_pkg::t_cmd          cmd;
    arc_pkg::t_stat         stat;
    logic                   cfg_we;
    logic [arc_pkg::PW-1:0] cap;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == arc_pkg::REG_CAP);
    assign prdata = (paddr[2] == arc_pkg::REG_CAP) ? 32'(cap) : '0;

    arc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    arc_dpath #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (pwdata[arc_pkg::PW-1:0]),
        .o_cap            (cap),
        .i_access_key     (i_access_key),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_found_in       (o_found_in),
        .o_released_valid (o_released_valid),
        .o_released_key   (o_released_key),
        .o_target_size    (o_target_size)
    );

endmodule

FILE: rtl/core/arc_check.sv
// ----------------------------------------------------------------------------
// arc_check
// Port-level checks of the replacement policy block, bound to the top level.
// ----------------------------------------------------------------------------
module arc_check #(
    parameter int KEY_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_hit,
    input logic [2:0]             o_found_in,
    input logic                   o_released_valid,
    input logic [KEY_WIDTH-1:0]   o_released_key,
    input logic [arc_pkg::PW-1:0] o_target_size
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found_in) && $stable(o_released_key)
                               && $stable(o_target_size))
        else $error("result changed while stalled");

    a_hit_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (o_found_in == arc_pkg::FOUND_T1 ||
                              o_found_in == arc_pkg::FOUND_T2))
        else $error("hit reported outside data lists");

    a_ghost_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_found_in == arc_pkg::FOUND_B1 || o_found_in == arc_pkg::FOUND_B2
                    || o_found_in == arc_pkg::FOUND_NONE) |-> !o_hit)
        else $error("miss reported as hit");

    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_released_valid |-> (o_released_key == '0))
        else $error("released key not zero without release");

endmodule

bind arc_replacement_policy arc_check #(
    .KEY_WIDTH (KEY_WIDTH)
) u_arc_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_hit            (o_hit),
    .o_found_in       (o_found_in),
    .o_released_valid (o_released_valid),
    .o_released_key   (o_released_key),
    .o_target_size    (o_target_size)
);
